FILE: rtl/mlpo_pkg.sv
// Shared types, constants and arithmetic helpers for the perceptron block.
// No dependencies; every other file in rtl/ imports this package.
package mlpo_pkg;

  localparam int INPUTS  = 8;
  localparam int HIDDEN  = 8;
  localparam int NW_HID  = HIDDEN * (INPUTS + 1);
  localparam int NW_ALL  = NW_HID + HIDDEN + 1;
  localparam int WI_W    = 7;
  localparam int IDX_W   = $clog2(INPUTS + 1);
  localparam int FS_W    = (INPUTS > 1) ? $clog2(INPUTS) : 1;
  localparam int CID_W   = $clog2(HIDDEN + 1);
  localparam int ACC_W   = 40;
  localparam int HDIV    = INPUTS * 4096;
  localparam int CNT_W   = $clog2(HIDDEN + INPUTS + 16);
  localparam int WAIT_A  = 6;
  localparam int WAIT_C  = 3;
  localparam int WAIT_D  = HIDDEN + 6;

  typedef enum logic [1:0] {
    OP_SUM,
    OP_OUT,
    OP_VUPD,
    OP_UPD
  } op_e;

  // One element moving along the row of neurons.
  typedef struct packed {
    logic                    vld;
    op_e                     op;
    logic [IDX_W-1:0]        idx;
    logic signed [ACC_W-1:0] data;
  } stream_t;

  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int n);
    logic signed [63:0] half;
    half = 64'sd1 <<< (n - 1);
    if (v >= 0) begin
      return (v + half) >>> n;
    end
    return -((-v + half) >>> n);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7fff;
    end
    if (v < -64'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic [11:0] sig_lut(input logic [5:0] k);
    logic [11:0] r;
    unique case (k)
      6'd0:  r = 12'd1;
      6'd1:  r = 12'd2;
      6'd2:  r = 12'd4;
      6'd3:  r = 12'd6;
      6'd4:  r = 12'd10;
      6'd5:  r = 12'd17;
      6'd6:  r = 12'd27;
      6'd7:  r = 12'd45;
      6'd8:  r = 12'd74;
      6'd9:  r = 12'd120;
      6'd10: r = 12'd194;
      6'd11: r = 12'd311;
      6'd12: r = 12'd488;
      6'd13: r = 12'd747;
      6'd14: r = 12'd1102;
      6'd15: r = 12'd1546;
      6'd16: r = 12'd2048;
      6'd17: r = 12'd2550;
      6'd18: r = 12'd2994;
      6'd19: r = 12'd3349;
      6'd20: r = 12'd3608;
      6'd21: r = 12'd3785;
      6'd22: r = 12'd3902;
      6'd23: r = 12'd3976;
      6'd24: r = 12'd4022;
      6'd25: r = 12'd4051;
      6'd26: r = 12'd4069;
      6'd27: r = 12'd4079;
      6'd28: r = 12'd4086;
      6'd29: r = 12'd4090;
      6'd30: r = 12'd4092;
      6'd31: r = 12'd4094;
      default: r = 12'd4095;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/mlpo_cell.sv
// One hidden neuron: its input weights, its output weight and its value.
// Depends on mlpo_pkg; forwards every stream element to the next neuron.
module mlpo_cell import mlpo_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [CID_W-1:0]        cell_id_i,
  input  logic                    wr_en_i,
  input  logic [WI_W-1:0]         wr_idx_i,
  input  logic signed [15:0]      wr_val_i,
  input  stream_t                 s_i,
  output stream_t                 s_o
);

  logic signed [15:0]      w_q [INPUTS+1];
  logic signed [15:0]      v_q;
  logic [14:0]             h_q;
  logic signed [30:0]      ae_q;
  logic signed [31:0]      hv_q;
  stream_t                 in_q;

  logic                    s1_vld_q, s2_vld_q, done_q, vu_q;
  op_e                     s1_op_q;
  logic [IDX_W-1:0]        s1_idx_q, s2_idx_q;
  logic signed [31:0]      m1_q;
  logic signed [62:0]      m2_q;
  logic signed [46:0]      mv_q;
  logic signed [ACC_W-1:0] acc_q;

  logic [WI_W:0]           hbase, hend, widx, hoff, vidx;
  logic signed [15:0]      hs, x, mb;
  logic signed [ACC_W-1:0] q;

  assign hs   = $signed({1'b0, h_q});
  assign x    = in_q.data[15:0];
  assign mb   = (in_q.op == OP_SUM) ? w_q[in_q.idx] : v_q;
  assign widx = {1'b0, wr_idx_i};
  assign hbase = (WI_W+1)'(cell_id_i) * (WI_W+1)'(INPUTS + 1);
  assign hend  = hbase + (WI_W+1)'(INPUTS + 1);
  assign hoff  = widx - hbase;
  assign vidx  = (WI_W+1)'(NW_HID) + (WI_W+1)'(cell_id_i);
  assign q     = (acc_q + ACC_W'(HDIV / 2)) / HDIV;

  always_comb begin
    s_o = in_q;
    if (in_q.op == OP_OUT) begin
      s_o.data = in_q.data + ACC_W'(hv_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q     <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      done_q   <= 1'b0;
      vu_q     <= 1'b0;
    end else begin
      in_q     <= s_i;
      s1_vld_q <= in_q.vld && (in_q.op == OP_SUM || in_q.op == OP_UPD);
      s2_vld_q <= s1_vld_q && (s1_op_q == OP_UPD) && (h_q != '0);
      done_q   <= s1_vld_q && (s1_op_q == OP_SUM) && (s1_idx_q == IDX_W'(INPUTS));
      vu_q     <= in_q.vld && (in_q.op == OP_VUPD);
    end
  end

  always_ff @(posedge clk_i) begin
    hv_q      <= hs * v_q;
    s1_op_q   <= in_q.op;
    s1_idx_q  <= in_q.idx;
    m1_q      <= x * mb;
    s2_idx_q  <= s1_idx_q;
    m2_q      <= m1_q * ae_q;
    if (s1_vld_q && s1_op_q == OP_SUM) begin
      acc_q <= ((s1_idx_q == '0) ? '0 : acc_q) + ACC_W'(m1_q);
    end
    if (done_q) begin
      if (acc_q <= 0) begin
        h_q <= '0;
      end else if (q > ACC_W'(32767)) begin
        h_q <= 15'h7fff;
      end else begin
        h_q <= q[14:0];
      end
    end
    if (in_q.vld && in_q.op == OP_VUPD) begin
      ae_q <= in_q.data[30:0];
      mv_q <= $signed(in_q.data[30:0]) * hs;
    end
    if (vu_q) begin
      v_q <= sat16(64'(v_q) + rnd_shift(64'(mv_q), 28));
    end else if (wr_en_i && widx == vidx) begin
      v_q <= wr_val_i;
    end
    if (s2_vld_q) begin
      w_q[s2_idx_q] <= sat16(64'(w_q[s2_idx_q]) + rnd_shift(64'(m2_q), 40));
    end else if (wr_en_i && widx >= hbase && widx < hend) begin
      w_q[hoff[IDX_W-1:0]] <= wr_val_i;
    end
  end

endmodule

FILE: rtl/mlp_one_hidden_train_infer.sv
// Top level of the one-hidden-layer perceptron with on-line training.
// Depends on mlpo_pkg and mlpo_cell.
//
// Weight writes and non-closing feature requests are taken only while idle. A closing
// feature request starts a sample: the features walk down a row of HIDDEN neuron cells,
// each with its own multipliers, to a result; when training is requested, the update
// then walks the row as well. The length of the row and the cell pipelines set the time
// that a sample takes. No input is taken while a sample is being processed. A finished
// result waits in the output register while training goes on.
module mlp_one_hidden_train_infer import mlpo_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        lr_we_i,
  input  logic [15:0] lr_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // feature[15:0], target[28:16], train[29], weight_index[36:30], weight_value[52:37]
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // last_feature
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // prediction[12:0], error[26:13]
  output logic [31:0] m_axis_tdata
);

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_SUM    = 14'b00000000000010,
    ST_WAIT_A = 14'b00000000000100,
    ST_OUT    = 14'b00000000001000,
    ST_WAIT_B = 14'b00000000010000,
    ST_Z      = 14'b00000000100000,
    ST_SIG    = 14'b00000001000000,
    ST_ERR    = 14'b00000010000000,
    ST_HOLD   = 14'b00000100000000,
    ST_AE     = 14'b00001000000000,
    ST_VUPD   = 14'b00010000000000,
    ST_WAIT_C = 14'b00100000000000,
    ST_UPD    = 14'b01000000000000,
    ST_WAIT_D = 14'b10000000000000
  } state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [IDX_W-1:0]        fcnt_q;
  logic signed [15:0]      fstore_q [INPUTS];
  logic [15:0]             lr_q;
  logic signed [15:0]      vb_q;
  logic [12:0]             tgt_q;
  logic                    train_q;
  logic signed [ACC_W-1:0] psum_q;
  logic signed [15:0]      z_q;
  logic [11:0]             lo_q;
  logic [22:0]             ip_q;
  logic [12:0]             p_q;
  logic signed [13:0]      e_q;
  logic signed [30:0]      ae_q;
  logic                    out_vld_q;
  logic [26:0]             out_q;

  logic                    acc, wr_en;
  logic [12:0]             tgt_in;
  logic signed [15:0]      xsel;
  logic [15:0]             pos;
  logic [11:0]             lo, hi;
  logic [12:0]             p_new;
  stream_t                 head;
  stream_t                 chain [HIDDEN];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign wr_en         = acc && s_axis_tuser;
  assign tgt_in        = (s_axis_tdata[28:16] > 13'd4096) ? 13'd4096 : s_axis_tdata[28:16];
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_q};

  // Feature positions not given in this sample read as zero; the bias input is -1.0.
  always_comb begin
    if (cnt_q == CNT_W'(INPUTS)) begin
      xsel = -16'sd4096;
    end else if (cnt_q < CNT_W'(fcnt_q)) begin
      xsel = fstore_q[cnt_q[FS_W-1:0]];
    end else begin
      xsel = '0;
    end
  end

  assign pos   = {~z_q[15], z_q[14:0]};
  assign lo    = sig_lut({1'b0, pos[15:11]});
  assign hi    = sig_lut({1'b0, pos[15:11]} + 6'd1);
  assign p_new = 13'(lo_q) + 13'((ip_q + 23'd1024) >> 11);

  always_comb begin
    head      = '0;
    head.idx  = cnt_q[IDX_W-1:0];
    head.data = ACC_W'(xsel);
    unique case (state_q)
      ST_SUM: begin
        head.vld = 1'b1;
        head.op  = OP_SUM;
      end
      ST_OUT: begin
        head.vld  = 1'b1;
        head.op   = OP_OUT;
        head.data = -(ACC_W'(vb_q) <<< 12);
      end
      ST_VUPD: begin
        head.vld  = 1'b1;
        head.op   = OP_VUPD;
        head.data = ACC_W'(ae_q);
      end
      ST_UPD: begin
        head.vld = 1'b1;
        head.op  = OP_UPD;
      end
      default: head.vld = 1'b0;
    endcase
  end

  for (genvar j = 0; j < HIDDEN; j++) begin : g_cell
    mlpo_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (CID_W'(j)),
      .wr_en_i   (wr_en),
      .wr_idx_i  (s_axis_tdata[36:30]),
      .wr_val_i  (s_axis_tdata[52:37]),
      .s_i       ((j == 0) ? head : chain[(j == 0) ? 0 : j - 1]),
      .s_o       (chain[j])
    );
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + CNT_W'(1);
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (acc && !s_axis_tuser && s_axis_tlast) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (cnt_q == CNT_W'(INPUTS)) begin
          cnt_d   = '0;
          state_d = ST_WAIT_A;
        end
      end
      ST_WAIT_A: begin
        if (cnt_q == CNT_W'(WAIT_A - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT:    state_d = ST_WAIT_B;
      ST_WAIT_B: begin
        if (chain[HIDDEN-1].vld && chain[HIDDEN-1].op == OP_OUT) begin
          state_d = ST_Z;
        end
      end
      ST_Z:   state_d = ST_SIG;
      ST_SIG: state_d = ST_ERR;
      ST_ERR: state_d = ST_HOLD;
      ST_HOLD: begin
        if (!out_vld_q) begin
          state_d = train_q ? ST_AE : ST_IDLE;
        end
      end
      ST_AE: state_d = ST_VUPD;
      ST_VUPD: begin
        cnt_d   = '0;
        state_d = ST_WAIT_C;
      end
      ST_WAIT_C: begin
        if (cnt_q == CNT_W'(WAIT_C - 1)) begin
          cnt_d   = '0;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (cnt_q == CNT_W'(INPUTS)) begin
          cnt_d   = '0;
          state_d = ST_WAIT_D;
        end
      end
      ST_WAIT_D: begin
        if (cnt_q == CNT_W'(WAIT_D - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      fcnt_q    <= '0;
      lr_q      <= 16'd655;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (lr_we_i) begin
        lr_q <= lr_wdata_i;
      end
      if (acc && !s_axis_tuser && fcnt_q < IDX_W'(INPUTS)) begin
        fcnt_q <= fcnt_q + IDX_W'(1);
      end else if (state_q != ST_IDLE && state_d == ST_IDLE) begin
        fcnt_q <= '0;
      end
      if (state_q == ST_HOLD && !out_vld_q) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && !s_axis_tuser && fcnt_q < IDX_W'(INPUTS)) begin
      fstore_q[fcnt_q[FS_W-1:0]] <= s_axis_tdata[15:0];
    end
    if (acc && !s_axis_tuser && s_axis_tlast) begin
      tgt_q   <= tgt_in;
      train_q <= s_axis_tdata[29];
    end
    if (wr_en && s_axis_tdata[36:30] == WI_W'(NW_ALL - 1)) begin
      vb_q <= s_axis_tdata[52:37];
    end else if (state_q == ST_VUPD) begin
      vb_q <= sat16(64'(vb_q) + rnd_shift(-(64'(ae_q) <<< 12), 28));
    end
    if (state_q == ST_WAIT_B) begin
      psum_q <= chain[HIDDEN-1].data;
    end
    z_q  <= sat16(rnd_shift(64'(psum_q), 12));
    lo_q <= lo;
    ip_q <= 23'(hi - lo) * 23'(pos[10:0]);
    if (state_q == ST_ERR) begin
      p_q <= p_new;
      e_q <= $signed({1'b0, tgt_q}) - $signed({1'b0, p_new});
    end
    if (state_q == ST_HOLD && !out_vld_q) begin
      out_q <= {e_q, p_q};
    end
    ae_q <= $signed({1'b0, lr_q}) * e_q;
  end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench for the one-hidden-layer perceptron: weight loads, samples, training.
// Depends on mlpo_pkg and the mlp_one_hidden_train_infer RTL; prediction is computed locally.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mlpo_pkg::INPUTS;
  import mlpo_pkg::HIDDEN;
  import mlpo_pkg::NW_HID;
  import mlpo_pkg::NW_ALL;

  localparam logic CMD_FEATURE = 1'b0;
  localparam logic CMD_WRITE   = 1'b1;
  localparam int   BIAS_Q12    = -4096;

  typedef struct packed {
    logic        cmd;
    logic [15:0] feature;
    logic        last;
    logic [12:0] target;
    logic        train;
    logic [6:0]  widx;
    logic [15:0] wval;
  } request_t;

  // Error sits above the prediction, as on the result bus.
  typedef struct packed {
    logic [13:0] error;
    logic [12:0] prediction;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        lr_we_i = 1'b0;
  logic [15:0] lr_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  mlp_one_hidden_train_infer u_top (
    .clk_i, .rst_ni, .lr_we_i, .lr_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Local copy of the network state.
  longint    hid_w [NW_HID];
  longint    out_w [HIDDEN+1];
  longint    feat_mem [INPUTS];
  longint    hid_val [HIDDEN];
  int        feat_cnt;
  longint    alpha_q16;
  int        sig_points [33] = '{1, 2, 4, 6, 10, 17, 27, 45, 74, 120, 194, 311, 488, 747,
    1102, 1546, 2048, 2550, 2994, 3349, 3608, 3785, 3902, 3976, 4022, 4051, 4069, 4079,
    4086, 4090, 4092, 4094, 4095};

  request_t  pending_q [$];
  answer_t   predicted_q [$];
  int        errors;
  int        samples_sent;

  function automatic longint sat_w(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint round_away(longint v, int n);
    longint half;
    half = longint'(1) << (n - 1);
    if (v >= 0) return (v + half) >>> n;
    return -((-v + half) >>> n);
  endfunction

  function automatic int sigmoid_approx(longint z);
    int pos, k, frac, lo, hi;
    pos  = int'(z) + 32768;
    k    = (pos >> 11) & 31;
    frac = pos & 2047;
    lo   = sig_points[k];
    hi   = sig_points[k+1];
    return lo + (((hi - lo) * frac + 1024) >> 11);
  endfunction

  task automatic predict_network(request_t r);
    longint x [INPUTS+1];
    longint acc, z, e, tgt, d, dh, hval;
    int     p;
    answer_t a;
    if (r.cmd == CMD_WRITE) begin
      if (r.widx < NW_HID) hid_w[r.widx] = longint'($signed(r.wval));
      else if (r.widx < NW_ALL) out_w[r.widx - NW_HID] = longint'($signed(r.wval));
      return;
    end
    if (feat_cnt < INPUTS) begin
      feat_mem[feat_cnt] = longint'($signed(r.feature));
      feat_cnt++;
    end
    if (!r.last) return;
    for (int i = 0; i < INPUTS; i++) x[i] = (i < feat_cnt) ? feat_mem[i] : 0;
    x[INPUTS] = BIAS_Q12;
    feat_cnt = 0;
    d = INPUTS * 4096;
    for (int j = 0; j < HIDDEN; j++) begin
      acc = 0;
      for (int i = 0; i <= INPUTS; i++) acc += x[i] * hid_w[j*(INPUTS+1)+i];
      if (acc <= 0) hid_val[j] = 0;
      else begin
        acc = (acc + d / 2) / d;
        hid_val[j] = (acc > 32767) ? 32767 : acc;
      end
    end
    acc = 0;
    for (int j = 0; j < HIDDEN; j++) acc += hid_val[j] * out_w[j];
    acc += BIAS_Q12 * out_w[HIDDEN];
    z = sat_w(round_away(acc, 12));
    p = sigmoid_approx(z);
    tgt = (r.target > 4096) ? 4096 : r.target;
    e = tgt - p;
    if (r.train) begin
      for (int j = 0; j <= HIDDEN; j++) begin
        hval = (j < HIDDEN) ? hid_val[j] : BIAS_Q12;
        out_w[j] = sat_w(out_w[j] + round_away(alpha_q16 * hval * e, 28));
      end
      for (int j = 0; j < HIDDEN; j++) begin
        if (hid_val[j] > 0) begin
          dh = out_w[j] * e;
          for (int i = 0; i <= INPUTS; i++)
            hid_w[j*(INPUTS+1)+i] = sat_w(hid_w[j*(INPUTS+1)+i]
                                     + round_away(alpha_q16 * x[i] * dh, 40));
        end
      end
    end
    a.prediction = p[12:0];
    a.error      = e[13:0];
    predicted_q.push_back(a);
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Driver: bursts of requests separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_network(pending_q.pop_front());
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          request_t nx;
          nx = pending_q[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nx.cmd;
          s_axis_tlast  <= nx.last;
          s_axis_tdata  <= {3'b000, nx.wval, nx.widx, nx.train, nx.target, nx.feature};
          if (burst_left <= 0) begin
            burst_left <= $urandom_range(12, 1);
            gap_left   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(5, 0);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor with its own stall pattern on the result side.
  int stall_phase = 0;
  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[26:0];
        if (predicted_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[15:0], 16'd0);
        end else begin
          want = predicted_q.pop_front();
          if (got.prediction !== want.prediction)
            report_mismatch("prediction", 16'(got.prediction), 16'(want.prediction));
          if (got.error !== want.error)
            report_mismatch("error", 16'(got.error), 16'(want.error));
        end
      end
      stall_phase <= (stall_phase + 1) % 23;
      m_axis_tready <= (stall_phase < 9) ? 1'b1 : ($urandom_range(3, 0) != 0);
    end
  end

  function automatic request_t make_write(int idx, int val);
    request_t r;
    r = '0;
    r.cmd = CMD_WRITE;
    r.widx = idx[6:0];
    r.wval = val[15:0];
    r.feature = 16'($urandom());
    r.target = 13'($urandom());
    r.train = 1'($urandom());
    r.last = 1'($urandom());
    return r;
  endfunction

  function automatic request_t make_feature(logic [15:0] f, logic last, logic [12:0] tgt,
                                            logic trn);
    request_t r;
    r = '0;
    r.cmd = CMD_FEATURE;
    r.feature = f;
    r.last = last;
    r.target = tgt;
    r.train = trn;
    r.widx = 7'($urandom());
    r.wval = 16'($urandom());
    return r;
  endfunction

  task automatic drain_and_settle();
    while (pending_q.size() > 0 || s_axis_tvalid || predicted_q.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_rate(logic [15:0] v);
    @(posedge clk_i);
    lr_we_i    <= 1'b1;
    lr_wdata_i <= v;
    alpha_q16 = v;
    @(posedge clk_i);
    lr_we_i    <= 1'b0;
  endtask

  function automatic int small_weight();
    return $urandom_range(3, 0) == 0 ? int'($urandom_range(65535, 0)) - 32768
                                     : int'($urandom_range(4000, 0)) - 2000;
  endfunction

  initial begin
    int n, len;
    logic [15:0] rates [4];
    rates = '{16'd0, 16'd65535, 16'd655, 16'd8000};
    errors = 0;
    feat_cnt = 0;
    alpha_q16 = 655;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Load every weight, then the directed samples.
    for (int k = 0; k < NW_ALL; k++) pending_q.push_back(make_write(k, small_weight()));
    pending_q.push_back(make_write(81, 16'h7fff));
    pending_q.push_back(make_write(127, 16'h8000));
    pending_q.push_back(make_feature(16'h7fff, 1'b1, 13'd4096, 1'b1));
    pending_q.push_back(make_feature(16'h8000, 1'b1, 13'd0, 1'b1));
    pending_q.push_back(make_feature(16'h1000, 1'b0, 13'd0, 1'b0));
    pending_q.push_back(make_write(3, 16'h0800));
    pending_q.push_back(make_feature(16'h2000, 1'b1, 13'd8191, 1'b0));
    for (int i = 0; i < 11; i++)
      pending_q.push_back(make_feature(16'(i * 3000), i == 10, 13'd5000, 1'b1));
    pending_q.push_back(make_feature(16'h0000, 1'b1, 13'd2048, 1'b0));
    drain_and_settle();

    for (int ph = 0; ph < 4; ph++) begin
      set_rate(rates[ph]);
      if (ph == 1) begin
        for (int k = 0; k < NW_ALL; k++)
          pending_q.push_back(make_write(k, int'($urandom_range(65535, 0)) - 32768));
      end
      n = 0;
      while (n < 115) begin
        if ($urandom_range(9, 0) == 0) begin
          pending_q.push_back(make_write($urandom_range(127, 0), $urandom_range(65535, 0)));
          n++;
        end else begin
          len = ($urandom_range(4, 0) == 0) ? $urandom_range(12, 1) : INPUTS;
          for (int i = 0; i < len; i++) begin
            pending_q.push_back(make_feature(
              ($urandom_range(3, 0) == 0) ? 16'($urandom()) : 16'($urandom_range(8192, 0) - 4096),
              i == len - 1, ($urandom_range(7, 0) == 0) ? 13'($urandom()) : 13'($urandom_range(4096, 0)),
              1'($urandom_range(1, 0))));
            if ($urandom_range(15, 0) == 0)
              pending_q.push_back(make_write($urandom_range(80, 0), small_weight()));
          end
          n += len;
        end
      end
      drain_and_settle();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: mlp_one_hidden_train_infer.f
rtl/mlpo_pkg.sv
rtl/mlpo_cell.sv
rtl/mlp_one_hidden_train_infer.sv
tb/sv/testbench.sv
